FILE: hdl/frapq_pkg.sv
// Shared types, constants and width helpers for the Fenwick range-add block.
package frapq_pkg;

  localparam int IDX_W           = 11;
  localparam int DATA_W          = 32;
  localparam int SIZE_W          = 11;
  localparam int SIZE_RESET      = 1024;
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Work kinds handed from the front end to the walk engine
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_ZERO  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              first_ok;
    logic              end_ok;
    logic [IDX_W-1:0]  first_idx;
    logic [IDX_W-1:0]  end_idx;
    logic [DATA_W-1:0] amount;
  } item_t;

  // Width of a walk position: holds any input index, the table size and p | (p+1)
  function automatic int walk_width(int max_entries);
    int aw;
    aw = $clog2(max_entries);
    return (aw > IDX_W) ? (aw + 1) : (IDX_W + 1);
  endfunction

endpackage

FILE: hdl/fenwick_range_add_point_query.sv
// Top level of the Fenwick range-add / point-query block with its APB register.
//
// Requests enter on the in_ channel (in_valid / in_stall). A request with
// in_func = 0 adds in_amount to every element in [in_first_index,
// in_end_index); in_func = 1 reads one element, returned on the out_ channel
// (out_valid / out_stall) as out_point_value. Adds give no result.
// Register active_size (byte address 0, reset 1024) limits the table; indexes
// at or above it are skipped by adds and read as 0 by queries. Write it only
// while the block is idle.
// After reset the tree is cleared one word a cycle through all MAX_ENTRIES words,
// with in_stall held high; register accesses work during that time.
// A two-entry queue separates intake from the walk engine. An add walks up
// from each update point in at most log2 of the size plus one steps; a query
// walks down from its index in at most log2 of the size read steps, one tree
// read per step on the single RAM read port. An add step is a read-modify-write
// overlapped with the next step's read.
// A stalled result holds in the output register; the next query still walks,
// then waits with everything behind it, and in_stall rises once the queue is full.
module fenwick_range_add_point_query import frapq_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [IDX_W-1:0]         in_first_index,
  input  logic [IDX_W-1:0]         in_end_index,
  input  logic signed [DATA_W-1:0] in_amount,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_point_value
);

  localparam int   PW              = walk_width(MAX_ENTRIES);
  localparam logic REG_ACTIVE_SIZE = 1'b0;

  logic [SIZE_W-1:0] active_size_r, active_size_nxt;
  logic [PW-1:0]     size_ext;
  logic [PW-1:0]     eff_size;
  logic              reg_sel;
  logic              clearing;
  logic              push;
  item_t             push_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == REG_ACTIVE_SIZE;
  assign prdata  = reg_sel ? {{(32-SIZE_W){1'b0}}, active_size_r} : '0;

  always_comb begin
    active_size_nxt = active_size_r;
    if (psel && penable && pwrite && reg_sel) begin
      active_size_nxt = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= SIZE_W'(SIZE_RESET);
    end else begin
      active_size_r <= active_size_nxt;
    end
  end

  // Clamp the register to the table depth
  assign size_ext = {{(PW-SIZE_W){1'b0}}, active_size_r};
  assign eff_size = (size_ext > PW'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : size_ext;

  frapq_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_first_index (in_first_index),
    .in_end_index   (in_end_index),
    .in_amount      (in_amount),
    .eff_size       (eff_size),
    .clearing       (clearing),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  frapq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_item)
  );

  frapq_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_size        (eff_size),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_value (out_point_value)
  );

endmodule

FILE: hdl/frapq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frapq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/frapq_front.sv
// Front end: accepts requests, checks indexes against the active size, classifies.
module frapq_front import frapq_pkg::*; #(
  parameter  int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int PW          = walk_width(MAX_ENTRIES)
) (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [IDX_W-1:0]         in_first_index,
  input  logic [IDX_W-1:0]         in_end_index,
  input  logic signed [DATA_W-1:0] in_amount,
  input  logic [PW-1:0]            eff_size,
  input  logic                     clearing,
  input  logic                     q_full,
  output logic                     push,
  output item_t                    push_item
);

  logic first_ok;
  logic end_ok;
  logic keep;

  assign first_ok = {{(PW-IDX_W){1'b0}}, in_first_index} < eff_size;
  assign end_ok   = {{(PW-IDX_W){1'b0}}, in_end_index} < eff_size;

  // Drop an add whose two update points both fall outside the table
  assign keep     = (in_func == FUNC_QUERY) || first_ok || end_ok;

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    push_item.first_ok  = first_ok;
    push_item.end_ok    = end_ok;
    push_item.first_idx = in_first_index;
    push_item.end_idx   = in_end_index;
    push_item.amount    = in_amount;
    if (in_func == FUNC_QUERY) begin
      push_item.op = first_ok ? OP_QUERY : OP_ZERO;
    end else begin
      push_item.op = OP_ADD;
    end
  end

endmodule

FILE: hdl/frapq_queue.sv
// Short request queue between the front end and the walk engine.
module frapq_queue import frapq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign valid = cnt_r != '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/frapq_back.sv
// Walk engine: clears the tree, runs update and query walks, holds the result register.
module frapq_back import frapq_pkg::*; #(
  parameter  int MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int AW          = $clog2(MAX_ENTRIES),
  localparam int PW          = walk_width(MAX_ENTRIES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [PW-1:0]            eff_size,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     clearing,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_point_value
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UP    = 5'b00100,
    ST_DOWN  = 5'b01000,
    ST_DFIN  = 5'b10000
  } state_t;

  state_t            st_r, st_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              second_r, second_nxt;
  logic [PW-1:0]     second_p_r, second_p_nxt;
  logic [DATA_W-1:0] sum_r, sum_nxt;
  logic              wr_vld_r, wr_vld_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_point_value_r, out_point_value_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [PW-1:0]     p_inc;
  logic [PW-1:0]     p_up;
  logic [PW-1:0]     p_low;
  logic              p_in_range;
  logic              out_free;

  assign p_inc      = p_r + PW'(1);
  assign p_up       = p_r | p_inc;
  assign p_low      = p_r & p_inc;
  assign p_in_range = p_r < eff_size;
  assign out_free   = !out_valid_r || !out_stall;

  assign clearing        = st_r == ST_CLEAR;
  assign out_valid       = out_valid_r;
  assign out_point_value = out_point_value_r;

  always_comb begin
    st_nxt              = st_r;
    clr_cnt_nxt         = clr_cnt_r;
    p_nxt               = p_r;
    val_nxt             = val_r;
    second_nxt          = second_r;
    second_p_nxt        = second_p_r;
    sum_nxt             = sum_r;
    wr_vld_nxt          = 1'b0;
    wr_addr_nxt         = wr_addr_r;
    rd_vld_nxt          = 1'b0;
    out_valid_nxt       = out_valid_r;
    out_point_value_nxt = out_point_value_r;
    q_pop               = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = wr_addr_r;
    ram_wdata           = ram_rdata + val_r;
    ram_re              = 1'b0;
    ram_raddr           = p_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    // Fold in the word read in the previous cycle of a query walk
    if (rd_vld_r) begin
      sum_nxt = sum_r + ram_rdata;
    end

    unique case (st_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MAX_ENTRIES-1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_ADD: begin
              st_nxt       = ST_UP;
              second_p_nxt = {{(PW-IDX_W){1'b0}}, q_item.end_idx};
              if (q_item.first_ok) begin
                p_nxt      = {{(PW-IDX_W){1'b0}}, q_item.first_idx};
                val_nxt    = q_item.amount;
                second_nxt = q_item.end_ok;
              end else begin
                p_nxt      = {{(PW-IDX_W){1'b0}}, q_item.end_idx};
                val_nxt    = '0 - q_item.amount;
                second_nxt = 1'b0;
              end
            end
            OP_QUERY: begin
              st_nxt  = ST_DOWN;
              p_nxt   = {{(PW-IDX_W){1'b0}}, q_item.first_idx};
              sum_nxt = '0;
            end
            default: begin
              st_nxt  = ST_DFIN;
              sum_nxt = '0;
            end
          endcase
        end
      end
      ST_UP: begin
        // Finish the read-modify-write of the previous step
        ram_we = wr_vld_r;
        if (p_in_range) begin
          ram_re      = 1'b1;
          wr_vld_nxt  = 1'b1;
          wr_addr_nxt = p_r[AW-1:0];
          p_nxt       = p_up;
        end else if (second_r) begin
          p_nxt      = second_p_r;
          val_nxt    = '0 - val_r;
          second_nxt = 1'b0;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_DOWN: begin
        ram_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        if (p_low == '0) begin
          st_nxt = ST_DFIN;
        end else begin
          p_nxt = p_low - PW'(1);
        end
      end
      ST_DFIN: begin
        if (!rd_vld_r && out_free) begin
          out_valid_nxt       = 1'b1;
          out_point_value_nxt = sum_r;
          st_nxt              = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      second_r    <= 1'b0;
      wr_vld_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      second_r    <= second_nxt;
      wr_vld_r    <= wr_vld_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r               <= p_nxt;
    val_r             <= val_nxt;
    second_p_r        <= second_p_nxt;
    sum_r             <= sum_nxt;
    wr_addr_r         <= wr_addr_nxt;
    out_point_value_r <= out_point_value_nxt;
  end

  frapq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_tree (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // An update walk never reads the word it is writing back in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("tree read and write hit the same word");

  // A pending write-back only exists inside an update walk
  a_wb_in_up: assert property (@(posedge clk) disable iff (!rst_n)
    wr_vld_r |-> (st_r == ST_UP))
    else $error("write-back pending outside an update walk");

  // Query read data is consumed only by the query states
  a_rd_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (st_r == ST_DOWN || st_r == ST_DFIN))
    else $error("query read data outside a query walk");

  // A new result appears only when a query finishes
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_DFIN))
    else $error("result raised outside query finish");

endmodule
